// File: hw/rtl/stk500v1_bootloader_command_engine_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bootloader command engine
// Property wrappers for the port checker.
// ---------------------------------------------------------------------------
`ifndef STK500V1_BOOTLOADER_COMMAND_ENGINE_CORE_DEFINES_SVH
`define STK500V1_BOOTLOADER_COMMAND_ENGINE_CORE_DEFINES_SVH

// clocked property, masked while in reset
`define STKBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, live through reset
`define STKBL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/stkbl_pkg.sv
// ---------------------------------------------------------------------------
// Bootloader command engine package
// Transfer types, result kinds, protocol bytes and sequencer phases.
// ---------------------------------------------------------------------------
package stkbl_pkg;

  typedef enum logic [2:0] {
    KIND_TX      = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_READ    = 3'd2,
    KIND_COMMIT  = 3'd3,
    KIND_SHORTEN = 3'd4,
    KIND_KICK    = 3'd5
  } kind_t;

  typedef enum logic {
    SRC_SERIAL = 1'b0,
    SRC_MEMORY = 1'b1
  } src_t;

  typedef struct packed {
    src_t       cmd;
    logic [7:0] data;
    logic       frame_error;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_out;
    logic [15:0] mem_address;
    logic        last;
  } out_item_t;

  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned RES_IDX_W   = 3;

  typedef enum logic [1:0] {
    CFG_VERSION   = 2'd0,
    CFG_SIGNATURE = 2'd1,
    CFG_PROG_BASE = 2'd2,
    CFG_EE_BASE   = 2'd3
  } cfg_idx_t;

  localparam logic [15:0] VERSION_RST   = 16'd2306;
  localparam logic [23:0] SIGNATURE_RST = 24'd2004561;
  localparam logic [15:0] PROG_BASE_RST = 16'd16384;
  localparam logic [15:0] EE_BASE_RST   = 16'd5120;

  localparam logic [7:0] BYTE_EOP    = 8'h20;
  localparam logic [7:0] BYTE_INSYNC = 8'h14;
  localparam logic [7:0] BYTE_OK     = 8'h10;

  localparam logic [7:0] CMD_GET_PARAM = 8'h41;
  localparam logic [7:0] CMD_SET_DEV   = 8'h42;
  localparam logic [7:0] CMD_SET_DEVX  = 8'h45;
  localparam logic [7:0] CMD_LOAD_ADDR = 8'h55;
  localparam logic [7:0] CMD_UNIVERSAL = 8'h56;
  localparam logic [7:0] CMD_PROG_PAGE = 8'h64;
  localparam logic [7:0] CMD_READ_PAGE = 8'h74;
  localparam logic [7:0] CMD_READ_SIGN = 8'h75;
  localparam logic [7:0] CMD_LEAVE     = 8'h51;

  localparam logic [7:0] PARAM_MINOR   = 8'h82;
  localparam logic [7:0] PARAM_MAJOR   = 8'h81;
  localparam logic [7:0] PARAM_OTHER   = 8'h03;
  localparam logic [7:0] UNIV_REPLY    = 8'h00;
  localparam logic [7:0] MEMTYPE_FLASH = 8'h46;

  localparam logic [4:0] SKIP_SET_DEV   = 5'd20;
  localparam logic [4:0] SKIP_SET_DEVX  = 5'd5;
  localparam logic [4:0] SKIP_UNIVERSAL = 5'd4;

  typedef enum logic [11:0] {
    PH_IDLE      = 12'b0000_0000_0001,
    PH_PARAM     = 12'b0000_0000_0010,
    PH_SKIP      = 12'b0000_0000_0100,
    PH_ADDR_LO   = 12'b0000_0000_1000,
    PH_ADDR_HI   = 12'b0000_0001_0000,
    PH_LEN_HI    = 12'b0000_0010_0000,
    PH_LEN_LO    = 12'b0000_0100_0000,
    PH_DTYPE     = 12'b0000_1000_0000,
    PH_PROG_DATA = 12'b0001_0000_0000,
    PH_EOP       = 12'b0010_0000_0000,
    PH_READ_WAIT = 12'b0100_0000_0000,
    PH_HALTED    = 12'b1000_0000_0000
  } phase_t;

  typedef enum logic [3:0] {
    PC_NONE      = 4'd0,
    PC_GETP      = 4'd1,
    PC_SKIPPED   = 4'd2,
    PC_LOADADDR  = 4'd3,
    PC_UNIVERSAL = 4'd4,
    PC_PROG      = 4'd5,
    PC_READ      = 4'd6,
    PC_SIGN      = 4'd7,
    PC_LEAVE     = 4'd8
  } pend_t;

endpackage

// File: hw/rtl/stk500v1_bootloader_command_engine_core.sv
// ---------------------------------------------------------------------------
// Bootloader command engine core
// Device side of the STK500v1 protocol: serial bytes and memory read data in,
// transmit, memory, page commit and watchdog results out.
// ---------------------------------------------------------------------------
// An input transfer loads the input register; once the result buffer is empty, or
// its last result is taken, the item is decoded into the result buffer.
// The buffer drains one result per cycle while out_ready is high, up to six per
// item; the input register takes the next item meanwhile. Reset (rst_n low,
// synchronous) clears sequencer state and result count and loads the register
// reset values; no clearing pass.
module stk500v1_bootloader_command_engine_core #(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned LEN_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  stkbl_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output stkbl_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  stkbl_pkg::cfg_idx_t  cfg_index,
  input  logic [23:0]          cfg_data
);

  localparam int unsigned NRES = stkbl_pkg::MAX_RESULTS;
  localparam int unsigned IW   = stkbl_pkg::RES_IDX_W;

  logic [15:0] ver_r;
  logic [23:0] sig_r;
  logic [15:0] pbase_r;
  logic [15:0] ebase_r;

  logic                inq_valid_r;
  stkbl_pkg::in_item_t inq_r;

  stkbl_pkg::phase_t     phase_r, phase_nxt;
  stkbl_pkg::pend_t      pend_r, pend_nxt;
  logic [ADDR_BITS-1:0]  cur_r, cur_nxt;
  logic [LEN_BITS-1:0]   rem_r, rem_nxt;
  logic [4:0]            skip_r, skip_nxt;
  logic [7:0]            psel_r, psel_nxt;

  stkbl_pkg::out_item_t  buf_r [NRES];
  stkbl_pkg::out_item_t  res [NRES];
  logic [IW-1:0]         n;
  logic [IW-1:0]         cnt_r;
  logic [IW-1:0]         idx_r;

  logic out_fire;
  logic drain_done;
  logic proc_fire;

  function automatic stkbl_pkg::out_item_t mk(stkbl_pkg::kind_t k, logic [7:0] b,
                                              logic [15:0] a);
    stkbl_pkg::out_item_t r;
    r.kind        = k;
    r.byte_out    = b;
    r.mem_address = a;
    r.last        = 1'b0;
    return r;
  endfunction

  assign cfg_ready  = 1'b1;
  assign out_valid  = (cnt_r != '0);
  assign out_fire   = out_valid && out_ready;
  assign drain_done = out_fire && (idx_r == cnt_r - IW'(1));
  assign proc_fire  = inq_valid_r && ((cnt_r == '0) || drain_done);
  assign in_ready   = !inq_valid_r || proc_fire;

  always_comb begin
    out_data      = buf_r[idx_r];
    out_data.last = (idx_r == cnt_r - IW'(1));
  end

  always_comb begin
    logic [15:0] a16;
    logic [7:0]  c;
    a16       = 16'(cur_r);
    c         = inq_r.data;
    n         = '0;
    for (int i = 0; i < NRES; i++) begin
      res[i] = mk(stkbl_pkg::KIND_TX, 8'h00, 16'h0000);
    end
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    cur_nxt   = cur_r;
    rem_nxt   = rem_r;
    skip_nxt  = skip_r;
    psel_nxt  = psel_r;

    if (phase_r != stkbl_pkg::PH_HALTED) begin
      if (inq_r.cmd == stkbl_pkg::SRC_SERIAL) begin
        if (phase_r != stkbl_pkg::PH_READ_WAIT) begin
          if (!inq_r.frame_error) begin
            res[n] = mk(stkbl_pkg::KIND_KICK, 8'h00, 16'h0000);
            n      = n + IW'(1);
          end
          unique case (phase_r)
            stkbl_pkg::PH_IDLE: begin
              pend_nxt  = stkbl_pkg::PC_NONE;
              phase_nxt = stkbl_pkg::PH_EOP;
              unique case (c)
                stkbl_pkg::CMD_GET_PARAM: begin
                  pend_nxt  = stkbl_pkg::PC_GETP;
                  phase_nxt = stkbl_pkg::PH_PARAM;
                end
                stkbl_pkg::CMD_SET_DEV: begin
                  pend_nxt  = stkbl_pkg::PC_SKIPPED;
                  skip_nxt  = stkbl_pkg::SKIP_SET_DEV;
                  phase_nxt = stkbl_pkg::PH_SKIP;
                end
                stkbl_pkg::CMD_SET_DEVX: begin
                  pend_nxt  = stkbl_pkg::PC_SKIPPED;
                  skip_nxt  = stkbl_pkg::SKIP_SET_DEVX;
                  phase_nxt = stkbl_pkg::PH_SKIP;
                end
                stkbl_pkg::CMD_LOAD_ADDR: begin
                  pend_nxt  = stkbl_pkg::PC_LOADADDR;
                  phase_nxt = stkbl_pkg::PH_ADDR_LO;
                end
                stkbl_pkg::CMD_UNIVERSAL: begin
                  pend_nxt  = stkbl_pkg::PC_UNIVERSAL;
                  skip_nxt  = stkbl_pkg::SKIP_UNIVERSAL;
                  phase_nxt = stkbl_pkg::PH_SKIP;
                end
                stkbl_pkg::CMD_PROG_PAGE: begin
                  pend_nxt  = stkbl_pkg::PC_PROG;
                  phase_nxt = stkbl_pkg::PH_LEN_HI;
                end
                stkbl_pkg::CMD_READ_PAGE: begin
                  pend_nxt  = stkbl_pkg::PC_READ;
                  phase_nxt = stkbl_pkg::PH_LEN_HI;
                end
                stkbl_pkg::CMD_READ_SIGN: begin
                  pend_nxt = stkbl_pkg::PC_SIGN;
                end
                stkbl_pkg::CMD_LEAVE: begin
                  pend_nxt = stkbl_pkg::PC_LEAVE;
                  res[n]   = mk(stkbl_pkg::KIND_SHORTEN, 8'h00, 16'h0000);
                  n        = n + IW'(1);
                end
                default: begin
                end
              endcase
            end
            stkbl_pkg::PH_PARAM: begin
              psel_nxt  = c;
              phase_nxt = stkbl_pkg::PH_EOP;
            end
            stkbl_pkg::PH_SKIP: begin
              skip_nxt = skip_r - 5'd1;
              if (skip_nxt == 5'd0) begin
                phase_nxt = stkbl_pkg::PH_EOP;
              end
            end
            stkbl_pkg::PH_ADDR_LO: begin
              cur_nxt[7:0] = c;
              phase_nxt    = stkbl_pkg::PH_ADDR_HI;
            end
            stkbl_pkg::PH_ADDR_HI: begin
              cur_nxt   = ADDR_BITS'({c, cur_r[7:0]});
              phase_nxt = stkbl_pkg::PH_EOP;
            end
            stkbl_pkg::PH_LEN_HI: begin
              rem_nxt   = LEN_BITS'(c);
              phase_nxt = stkbl_pkg::PH_LEN_LO;
            end
            stkbl_pkg::PH_LEN_LO: begin
              rem_nxt   = LEN_BITS'({rem_r[7:0], c});
              phase_nxt = stkbl_pkg::PH_DTYPE;
            end
            stkbl_pkg::PH_DTYPE: begin
              cur_nxt   = cur_r + ((c == stkbl_pkg::MEMTYPE_FLASH) ? ADDR_BITS'(pbase_r)
                                                                   : ADDR_BITS'(ebase_r));
              phase_nxt = (pend_r == stkbl_pkg::PC_PROG) ? stkbl_pkg::PH_PROG_DATA
                                                         : stkbl_pkg::PH_EOP;
            end
            stkbl_pkg::PH_PROG_DATA: begin
              res[n]  = mk(stkbl_pkg::KIND_WRITE, c, a16);
              n       = n + IW'(1);
              cur_nxt = cur_r + ADDR_BITS'(1);
              rem_nxt = rem_r - LEN_BITS'(1);
              if (rem_nxt == '0) begin
                phase_nxt = stkbl_pkg::PH_EOP;
              end
            end
            stkbl_pkg::PH_EOP: begin
              if (c != stkbl_pkg::BYTE_EOP) begin
                res[n]    = mk(stkbl_pkg::KIND_SHORTEN, 8'h00, 16'h0000);
                n         = n + IW'(1);
                phase_nxt = stkbl_pkg::PH_HALTED;
              end else begin
                res[n]    = mk(stkbl_pkg::KIND_TX, stkbl_pkg::BYTE_INSYNC, 16'h0000);
                n         = n + IW'(1);
                phase_nxt = stkbl_pkg::PH_IDLE;
                pend_nxt  = stkbl_pkg::PC_NONE;
                case (pend_r)
                  stkbl_pkg::PC_GETP: begin
                    if (psel_r == stkbl_pkg::PARAM_MINOR) begin
                      res[n] = mk(stkbl_pkg::KIND_TX, ver_r[7:0], 16'h0000);
                    end else if (psel_r == stkbl_pkg::PARAM_MAJOR) begin
                      res[n] = mk(stkbl_pkg::KIND_TX, ver_r[15:8], 16'h0000);
                    end else begin
                      res[n] = mk(stkbl_pkg::KIND_TX, stkbl_pkg::PARAM_OTHER, 16'h0000);
                    end
                    n = n + IW'(1);
                  end
                  stkbl_pkg::PC_UNIVERSAL: begin
                    res[n] = mk(stkbl_pkg::KIND_TX, stkbl_pkg::UNIV_REPLY, 16'h0000);
                    n      = n + IW'(1);
                  end
                  stkbl_pkg::PC_PROG: begin
                    res[n] = mk(stkbl_pkg::KIND_COMMIT, 8'h00, 16'h0000);
                    n      = n + IW'(1);
                  end
                  stkbl_pkg::PC_SIGN: begin
                    res[n] = mk(stkbl_pkg::KIND_TX, sig_r[23:16], 16'h0000);
                    n      = n + IW'(1);
                    res[n] = mk(stkbl_pkg::KIND_TX, sig_r[15:8], 16'h0000);
                    n      = n + IW'(1);
                    res[n] = mk(stkbl_pkg::KIND_TX, sig_r[7:0], 16'h0000);
                    n      = n + IW'(1);
                  end
                  default: begin
                  end
                endcase
                if (pend_r == stkbl_pkg::PC_READ) begin
                  res[n]    = mk(stkbl_pkg::KIND_READ, 8'h00, a16);
                  n         = n + IW'(1);
                  cur_nxt   = cur_r + ADDR_BITS'(1);
                  phase_nxt = stkbl_pkg::PH_READ_WAIT;
                end else begin
                  res[n] = mk(stkbl_pkg::KIND_TX, stkbl_pkg::BYTE_OK, 16'h0000);
                  n      = n + IW'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end else if (phase_r == stkbl_pkg::PH_READ_WAIT) begin
        res[n]  = mk(stkbl_pkg::KIND_TX, c, 16'h0000);
        n       = n + IW'(1);
        rem_nxt = rem_r - LEN_BITS'(1);
        if (rem_nxt != '0) begin
          res[n]  = mk(stkbl_pkg::KIND_READ, 8'h00, a16);
          n       = n + IW'(1);
          cur_nxt = cur_r + ADDR_BITS'(1);
        end else begin
          res[n]    = mk(stkbl_pkg::KIND_TX, stkbl_pkg::BYTE_OK, 16'h0000);
          n         = n + IW'(1);
          phase_nxt = stkbl_pkg::PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r       <= stkbl_pkg::VERSION_RST;
      sig_r       <= stkbl_pkg::SIGNATURE_RST;
      pbase_r     <= stkbl_pkg::PROG_BASE_RST;
      ebase_r     <= stkbl_pkg::EE_BASE_RST;
      inq_valid_r <= 1'b0;
      phase_r     <= stkbl_pkg::PH_IDLE;
      pend_r      <= stkbl_pkg::PC_NONE;
      cur_r       <= '0;
      rem_r       <= '0;
      skip_r      <= '0;
      psel_r      <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          stkbl_pkg::CFG_VERSION:   ver_r   <= cfg_data[15:0];
          stkbl_pkg::CFG_SIGNATURE: sig_r   <= cfg_data;
          stkbl_pkg::CFG_PROG_BASE: pbase_r <= cfg_data[15:0];
          stkbl_pkg::CFG_EE_BASE:   ebase_r <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (in_ready) begin
        inq_valid_r <= in_valid;
      end
      if (proc_fire) begin
        phase_r <= phase_nxt;
        pend_r  <= pend_nxt;
        cur_r   <= cur_nxt;
        rem_r   <= rem_nxt;
        skip_r  <= skip_nxt;
        psel_r  <= psel_nxt;
        cnt_r   <= n;
        idx_r   <= '0;
      end else if (out_fire) begin
        if (drain_done) begin
          cnt_r <= '0;
          idx_r <= '0;
        end else begin
          idx_r <= idx_r + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_r <= in_data;
    end
    if (proc_fire) begin
      for (int i = 0; i < NRES; i++) begin
        buf_r[i] <= res[i];
      end
    end
  end

endmodule

// File: hw/rtl/stkbl_checker.sv
// ---------------------------------------------------------------------------
// Bootloader command engine port checker
// Watches the result channel of the top level and is bound to it.
// ---------------------------------------------------------------------------
`include "stk500v1_bootloader_command_engine_core_defines.svh"

module stkbl_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input stkbl_pkg::out_item_t out_data
);

  `STKBL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped or changed while stalled")
  `STKBL_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result shown straight after reset")
  `STKBL_ASSERT(a_kind_range, out_valid |-> out_data.kind <= stkbl_pkg::KIND_KICK, "result kind out of range")
  `STKBL_ASSERT(a_byte_zero, out_valid && out_data.kind != stkbl_pkg::KIND_TX && out_data.kind != stkbl_pkg::KIND_WRITE |-> out_data.byte_out == 8'h00, "stray byte on non-data result")

endmodule

bind stk500v1_bootloader_command_engine_core stkbl_checker u_stkbl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: test/stkbl_reply_checker.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Bootloader command engine reply checker
// Follows the protocol sequencer from every input and register transfer, queues
// the replies each input transfer must cause and compares every result transfer,
// field by field, with the oldest queued reply.
// -----------------------------------------------------------------------------
module stkbl_reply_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  stkbl_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  stkbl_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  stkbl_pkg::cfg_idx_t  cfg_index,
  input  logic [23:0]          cfg_data,
  output int                   fail_count,
  output int                   replies_pending,
  output int                   replies_checked
);
  import stkbl_pkg::*;

  logic [15:0] version_reg;
  logic [23:0] sig_reg;
  logic [15:0] prog_base_reg;
  logic [15:0] ee_base_reg;

  phase_t      seq_phase;
  pend_t       open_cmd;
  logic [15:0] page_addr;
  logic [15:0] bytes_left;
  logic [4:0]  skip_left;
  logic [7:0]  param_sel;

  out_item_t   batch [MAX_RESULTS];
  int          batch_n;
  out_item_t   reply_q [$];
  out_item_t   want;
  int          fails = 0;
  int          checked = 0;

  function automatic void add_reply(input kind_t k, input logic [7:0] b,
                                    input logic [15:0] a);
    out_item_t r;
    r.kind        = k;
    r.byte_out    = b;
    r.mem_address = a;
    r.last        = 1'b0;
    batch[batch_n] = r;
    batch_n++;
  endfunction

  function automatic void request_read();
    add_reply(KIND_READ, 8'h00, page_addr);
    page_addr = page_addr + 16'd1;
  endfunction

  function automatic void predict_replies(input in_item_t item);
    logic [7:0] c;
    out_item_t  r;
    int         i;
    c       = item.data;
    batch_n = 0;
    if (seq_phase != PH_HALTED) begin
      if (item.cmd == SRC_SERIAL) begin
        if (seq_phase != PH_READ_WAIT) begin
          if (!item.frame_error) add_reply(KIND_KICK, 8'h00, 16'h0000);
          case (seq_phase)
            PH_IDLE: begin
              open_cmd  = PC_NONE;
              seq_phase = PH_EOP;
              case (c)
                CMD_GET_PARAM: begin
                  open_cmd  = PC_GETP;
                  seq_phase = PH_PARAM;
                end
                CMD_SET_DEV: begin
                  open_cmd  = PC_SKIPPED;
                  skip_left = SKIP_SET_DEV;
                  seq_phase = PH_SKIP;
                end
                CMD_SET_DEVX: begin
                  open_cmd  = PC_SKIPPED;
                  skip_left = SKIP_SET_DEVX;
                  seq_phase = PH_SKIP;
                end
                CMD_LOAD_ADDR: begin
                  open_cmd  = PC_LOADADDR;
                  seq_phase = PH_ADDR_LO;
                end
                CMD_UNIVERSAL: begin
                  open_cmd  = PC_UNIVERSAL;
                  skip_left = SKIP_UNIVERSAL;
                  seq_phase = PH_SKIP;
                end
                CMD_PROG_PAGE: begin
                  open_cmd  = PC_PROG;
                  seq_phase = PH_LEN_HI;
                end
                CMD_READ_PAGE: begin
                  open_cmd  = PC_READ;
                  seq_phase = PH_LEN_HI;
                end
                CMD_READ_SIGN: open_cmd = PC_SIGN;
                CMD_LEAVE: begin
                  open_cmd = PC_LEAVE;
                  add_reply(KIND_SHORTEN, 8'h00, 16'h0000);
                end
                default: ;
              endcase
            end
            PH_PARAM: begin
              param_sel = c;
              seq_phase = PH_EOP;
            end
            PH_SKIP: begin
              skip_left = skip_left - 5'd1;
              if (skip_left == 5'd0) seq_phase = PH_EOP;
            end
            PH_ADDR_LO: begin
              page_addr[7:0] = c;
              seq_phase      = PH_ADDR_HI;
            end
            PH_ADDR_HI: begin
              page_addr[15:8] = c;
              seq_phase       = PH_EOP;
            end
            PH_LEN_HI: begin
              bytes_left = {8'h00, c};
              seq_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              bytes_left = {bytes_left[7:0], c};
              seq_phase  = PH_DTYPE;
            end
            PH_DTYPE: begin
              page_addr = page_addr + ((c == MEMTYPE_FLASH) ? prog_base_reg : ee_base_reg);
              seq_phase = (open_cmd == PC_PROG) ? PH_PROG_DATA : PH_EOP;
            end
            PH_PROG_DATA: begin
              add_reply(KIND_WRITE, c, page_addr);
              page_addr  = page_addr + 16'd1;
              bytes_left = bytes_left - 16'd1;
              if (bytes_left == 16'd0) seq_phase = PH_EOP;
            end
            default: begin
              if (c != BYTE_EOP) begin
                add_reply(KIND_SHORTEN, 8'h00, 16'h0000);
                seq_phase = PH_HALTED;
              end else begin
                add_reply(KIND_TX, BYTE_INSYNC, 16'h0000);
                seq_phase = PH_IDLE;
                case (open_cmd)
                  PC_GETP: begin
                    if (param_sel == PARAM_MINOR) add_reply(KIND_TX, version_reg[7:0], 16'h0000);
                    else if (param_sel == PARAM_MAJOR)
                      add_reply(KIND_TX, version_reg[15:8], 16'h0000);
                    else add_reply(KIND_TX, PARAM_OTHER, 16'h0000);
                  end
                  PC_UNIVERSAL: add_reply(KIND_TX, UNIV_REPLY, 16'h0000);
                  PC_PROG: add_reply(KIND_COMMIT, 8'h00, 16'h0000);
                  PC_SIGN: begin
                    add_reply(KIND_TX, sig_reg[23:16], 16'h0000);
                    add_reply(KIND_TX, sig_reg[15:8], 16'h0000);
                    add_reply(KIND_TX, sig_reg[7:0], 16'h0000);
                  end
                  default: ;
                endcase
                if (open_cmd == PC_READ) begin
                  request_read();
                  seq_phase = PH_READ_WAIT;
                end else begin
                  add_reply(KIND_TX, BYTE_OK, 16'h0000);
                end
                open_cmd = PC_NONE;
              end
            end
          endcase
        end
      end else if (seq_phase == PH_READ_WAIT) begin
        add_reply(KIND_TX, c, 16'h0000);
        bytes_left = bytes_left - 16'd1;
        if (bytes_left != 16'd0) begin
          request_read();
        end else begin
          add_reply(KIND_TX, BYTE_OK, 16'h0000);
          seq_phase = PH_IDLE;
        end
      end
    end
    for (i = 0; i < batch_n; i++) begin
      r      = batch[i];
      r.last = (i == batch_n - 1);
      reply_q.push_back(r);
    end
  endfunction

  function automatic void flag_field(input string field, input logic [15:0] exp_val,
                                     input logic [15:0] got_val);
    fails++;
    $error("result field %s: expected %0h, got %0h", field, exp_val, got_val);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      version_reg   = VERSION_RST;
      sig_reg       = SIGNATURE_RST;
      prog_base_reg = PROG_BASE_RST;
      ee_base_reg   = EE_BASE_RST;
      seq_phase     = PH_IDLE;
      open_cmd      = PC_NONE;
      page_addr     = 16'h0000;
      bytes_left    = 16'h0000;
      skip_left     = 5'd0;
      param_sel     = 8'h00;
      reply_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        checked++;
        if (reply_q.size() == 0) begin
          fails++;
          $error("result transfer with no reply due: kind %0d byte %02h address %04h",
                 out_data.kind, out_data.byte_out, out_data.mem_address);
        end else begin
          want = reply_q.pop_front();
          if (out_data.kind !== want.kind)
            flag_field("kind", 16'(want.kind), 16'(out_data.kind));
          if (out_data.byte_out !== want.byte_out)
            flag_field("byte_out", 16'(want.byte_out), 16'(out_data.byte_out));
          if (out_data.mem_address !== want.mem_address)
            flag_field("mem_address", want.mem_address, out_data.mem_address);
          if (out_data.last !== want.last)
            flag_field("last", 16'(want.last), 16'(out_data.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VERSION:   version_reg   = cfg_data[15:0];
          CFG_SIGNATURE: sig_reg       = cfg_data;
          CFG_PROG_BASE: prog_base_reg = cfg_data[15:0];
          CFG_EE_BASE:   ee_base_reg   = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_replies(in_data);
    end
    fail_count      <= fails;
    replies_pending <= reply_q.size();
    replies_checked <= checked;
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Bootloader command engine testbench
// Drives whole protocol commands, stray memory data and dropped serial bytes
// into the engine under varying register settings and back-pressure, ending
// with a missing end-of-packet that halts the engine.
// -----------------------------------------------------------------------------
module tb_top;
  import stkbl_pkg::*;

  localparam int DRAIN_CYCLES = 16;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_idx_t   cfg_index;
  logic [23:0] cfg_data;

  int fail_count;
  int replies_pending;
  int replies_checked;

  int send_idle_pct = 27;
  int recv_idle_pct = 67;
  int ferr_pct      = 50;
  int noise_pct     = 0;
  int items_sent    = 0;
  int items_ignored = 0;

  always #5 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  stk500v1_bootloader_command_engine_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stkbl_reply_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .replies_pending (replies_pending),
    .replies_checked (replies_checked)
  );

  task automatic send_item(input in_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic ser(input logic [7:0] b);
    in_item_t item;
    item.cmd         = SRC_SERIAL;
    item.data        = b;
    item.frame_error = ($urandom_range(99) < ferr_pct);
    send_item(item);
  endtask

  task automatic mem(input logic [7:0] b);
    in_item_t item;
    item.cmd         = SRC_MEMORY;
    item.data        = b;
    item.frame_error = 1'($urandom_range(1));
    send_item(item);
  endtask

  task automatic issue(input logic [7:0] op, input logic [15:0] len, input logic [7:0] mtype,
                       input logic [15:0] addr, input logic [7:0] sel);
    int n;
    int i;
    n = (len == 16'd0) ? 65536 : int'(len);
    if ($urandom_range(99) < noise_pct) begin
      mem(8'($urandom_range(255)));
      items_ignored++;
    end
    ser(op);
    case (op)
      CMD_GET_PARAM: ser(sel);
      CMD_SET_DEV:   repeat (SKIP_SET_DEV) ser(8'($urandom_range(255)));
      CMD_SET_DEVX:  repeat (SKIP_SET_DEVX) ser(8'($urandom_range(255)));
      CMD_UNIVERSAL: repeat (SKIP_UNIVERSAL) ser(8'($urandom_range(255)));
      CMD_LOAD_ADDR: begin
        ser(addr[7:0]);
        ser(addr[15:8]);
      end
      CMD_PROG_PAGE, CMD_READ_PAGE: begin
        ser(len[15:8]);
        ser(len[7:0]);
        ser(mtype);
        if (op == CMD_PROG_PAGE) repeat (n) ser(8'($urandom_range(255)));
      end
      default: ;
    endcase
    ser(BYTE_EOP);
    if (op == CMD_READ_PAGE) begin
      for (i = 0; i < n; i++) begin
        if ($urandom_range(99) < noise_pct) begin
          ser(8'($urandom_range(255)));
          items_ignored++;
        end
        mem(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic random_phase(input int count);
    int          goal;
    int          w;
    logic [7:0]  op;
    logic [7:0]  sel;
    logic [7:0]  mtype;
    logic [15:0] len;
    goal = items_sent - items_ignored + count;
    while (items_sent - items_ignored < goal) begin
      w     = $urandom_range(99);
      len   = ($urandom_range(99) < 4) ? 16'($urandom_range(300, 9)) :
                                         16'($urandom_range(8, 1));
      sel   = ($urandom_range(2) == 0) ? PARAM_MINOR :
              ($urandom_range(1) == 0) ? PARAM_MAJOR : 8'($urandom_range(255));
      mtype = ($urandom_range(1) == 0) ? MEMTYPE_FLASH : 8'($urandom_range(255));
      if (w < 12) op = CMD_GET_PARAM;
      else if (w < 17) op = CMD_SET_DEV;
      else if (w < 23) op = CMD_SET_DEVX;
      else if (w < 38) op = CMD_LOAD_ADDR;
      else if (w < 46) op = CMD_UNIVERSAL;
      else if (w < 64) op = CMD_PROG_PAGE;
      else if (w < 78) op = CMD_READ_PAGE;
      else if (w < 86) op = CMD_READ_SIGN;
      else if (w < 91) op = CMD_LEAVE;
      else begin
        op = 8'($urandom_range(255));
        while (op == CMD_GET_PARAM || op == CMD_SET_DEV || op == CMD_SET_DEVX ||
               op == CMD_LOAD_ADDR || op == CMD_UNIVERSAL || op == CMD_PROG_PAGE ||
               op == CMD_READ_PAGE || op == CMD_READ_SIGN || op == CMD_LEAVE)
          op = 8'($urandom_range(255));
      end
      issue(op, len, mtype, 16'($urandom), sel);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] ver, input logic [23:0] sig,
                              input logic [15:0] pbase, input logic [15:0] ebase);
    logic [23:0] vals [4];
    int          i;
    vals[0] = {8'h00, ver};
    vals[1] = sig;
    vals[2] = {8'h00, pbase};
    vals[3] = {8'h00, ebase};
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_VERSION;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, address wrap, extremes, stray and dropped bytes
    mem(8'hFF);
    items_ignored++;
    issue(CMD_LOAD_ADDR, 16'h0000, 8'h00, 16'hFFFF, 8'h00);
    issue(CMD_PROG_PAGE, 16'h0001, MEMTYPE_FLASH, 16'h0000, 8'h00);
    issue(CMD_GET_PARAM, 16'h0000, 8'h00, 16'h0000, PARAM_MINOR);
    issue(CMD_UNIVERSAL, 16'h0000, 8'h00, 16'h0000, 8'h00);
    noise_pct = 100;
    issue(CMD_READ_PAGE, 16'h0001, 8'h00, 16'h0000, 8'h00);
    noise_pct = 0;
    issue(CMD_READ_SIGN, 16'h0000, 8'h00, 16'h0000, 8'h00);
    drain();

    program_regs(16'hFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
    ferr_pct  = 10;
    noise_pct = 10;
    random_phase(127);
    drain();

    send_idle_pct = 67;
    recv_idle_pct = 27;
    program_regs(16'h0000, 24'h000000, 16'h0000, 16'h0000);
    random_phase(127);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(16'($urandom), 24'($urandom), 16'($urandom), 16'($urandom));
    random_phase(126);

    // missing end-of-packet halts the engine; everything after is dropped
    noise_pct = 0;
    ferr_pct  = 0;
    ser(CMD_GET_PARAM);
    ser(PARAM_MAJOR);
    ser(8'hDF);
    ser(BYTE_EOP);
    mem(8'h00);
    ser(CMD_READ_SIGN);
    items_ignored += 3;
    drain();

    $display("Covered %0d input transfers (%0d dropped or ignored) and %0d result transfers,",
             items_sent, items_ignored, replies_checked);
    $display("over reset, all-ones, all-zero and random settings, pages up to 300 bytes.");
    if (fail_count == 0 && replies_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/stkbl_pkg.sv
hw/rtl/stk500v1_bootloader_command_engine_core.sv
hw/rtl/stkbl_checker.sv
test/stkbl_reply_checker.sv
test/tb_top.sv
